/* rtl/iar_pkg.sv */
// Shared types, constants and helper functions of the integer to ASCII converter.
package iar_pkg;

   // Default width of the number to convert.
   localparam int VALUE_BITS_DEF = 32;

   // Longest string of characters emitted for one number, sign included.
   localparam int MAX_CHARS = 11;

   // ASCII codes used by the character formatter.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ALPHA = 8'h37;  // 'A' minus ten

   // Format selector carried with each input transfer.
   typedef enum logic [1:0] {
      OP_UDEC = 2'd0,
      OP_SDEC = 2'd1,
      OP_HEX  = 2'd2,
      OP_OCT  = 2'd3
   } op_type;

   // Radix used by the digit bank.
   typedef enum logic [1:0] {
      BASE_DEC,
      BASE_HEX,
      BASE_OCT
   } base_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_SCAN,
      S_SIGN,
      S_EMIT
   } state_type;

   // Control from the sequencer to the digit bank.
   typedef struct packed {
      logic     clear;
      logic     shift;
      logic     bit_in;
      base_type base;
      logic     negative;
   } bank_ctrl_type;

   // Status from the digit bank to the sequencer.
   typedef struct packed {
      logic [3:0] digit;
      logic       overflow;
   } bank_stat_type;

   // One character handed from the sequencer to the output register.
   typedef struct packed {
      logic       load;
      logic [7:0] char_code;
      logic       last;
   } emit_type;

   // Number of digit positions needed for the widest case (octal).
   function automatic int num_digits(input int bits);
      return (bits + 2) / 3;
   endfunction

   // ASCII code of one digit value, uppercase letters above nine.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] code;
      if (d < 4'd10) begin
         code = CH_ZERO + {4'b0000, d};
      end else begin
         code = CH_ALPHA + {4'b0000, d};
      end
      return code;
   endfunction

endpackage

/* rtl/iar_digit_bank.sv */
// Digit register bank with the shared shift-and-double unit for radix 10, 16 and 8.
module iar_digit_bank
   import iar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int NDIG       = num_digits(VALUE_BITS),
   parameter int PTR_W      = $clog2(NDIG)
) (
   input  logic          clock,
   input  bank_ctrl_type ctrl,
   input  logic [PTR_W-1:0] ptr,
   output bank_stat_type stat
);

   logic [3:0] digit_ff [NDIG];
   logic [3:0] digit_in [NDIG];
   logic [NDIG-1:0] carry;
   logic [3:0] half;
   logic [4:0] base5;

   // Radix constants: a digit at or above half the radix carries out when doubled.
   always_comb begin
      unique case (ctrl.base)
         BASE_HEX: begin
            half  = 4'd8;
            base5 = 5'd16;
         end
         BASE_OCT: begin
            half  = 4'd4;
            base5 = 5'd8;
         end
         default: begin
            half  = 4'd5;
            base5 = 5'd10;
         end
      endcase
   end

   // Each digit doubles and takes the carry of the digit below; no ripple is needed
   // because a digit's carry out depends only on its own value.
   always_comb begin
      logic       cin;
      logic [4:0] sum;
      logic [4:0] nxt;
      for (int i = 0; i < NDIG; i++) begin
         carry[i] = (digit_ff[i] >= half);
      end
      for (int i = 0; i < NDIG; i++) begin
         cin = (i == 0) ? ctrl.bit_in : carry[(i == 0) ? 0 : i - 1];
         sum = {digit_ff[i], cin};
         nxt = carry[i] ? (sum - base5) : sum;
         if (ctrl.clear) begin
            digit_in[i] = 4'd0;
         end else if (ctrl.shift) begin
            digit_in[i] = nxt[3:0];
         end else begin
            digit_in[i] = digit_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NDIG; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   // Read port at the sequencer's pointer. A nonzero digit beyond the character
   // budget means the string is cut to its least significant digits and no
   // leading zero is suppressed.
   always_comb begin
      logic over_full;
      logic over_neg;
      if ({1'b0, ptr} < (PTR_W + 1)'(NDIG)) begin
         stat.digit = digit_ff[ptr];
      end else begin
         stat.digit = 4'd0;
      end
      over_full = 1'b0;
      over_neg  = 1'b0;
      for (int i = 0; i < NDIG; i++) begin
         if (i >= MAX_CHARS && digit_ff[i] != 4'd0) begin
            over_full = 1'b1;
         end
         if (i >= MAX_CHARS - 1 && digit_ff[i] != 4'd0) begin
            over_neg = 1'b1;
         end
      end
      stat.overflow = ctrl.negative ? over_neg : over_full;
   end

endmodule

/* rtl/iar_sequencer.sv */
// Sequencer: loads a number, runs the digit bank one bit per cycle, then emits characters.
module iar_sequencer
   import iar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int NDIG       = num_digits(VALUE_BITS),
   parameter int PTR_W      = $clog2(NDIG)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  out_free,
   output emit_type              emit,
   output bank_ctrl_type         ctrl,
   output logic [PTR_W-1:0]      ptr,
   input  bank_stat_type         stat
);

   localparam int CNT_W     = $clog2(VALUE_BITS);
   localparam int START_POS = (NDIG - 1 < MAX_CHARS - 1) ? NDIG - 1 : MAX_CHARS - 1;
   localparam int START_NEG = (NDIG - 1 < MAX_CHARS - 2) ? NDIG - 1 : MAX_CHARS - 2;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic                  neg_ff, neg_in;
   base_type              base_ff, base_in;

   logic                  accept;
   logic                  req_neg;
   logic                  scan_skip;

   assign accept    = req_valid && req_ready;
   assign req_neg   = (op_type'(req_op) == OP_SDEC) && req_value[VALUE_BITS-1];
   assign scan_skip = !stat.overflow && (ptr_ff != '0) && (stat.digit == 4'd0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (cnt_ff == '0) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!scan_skip) begin
               state_in = neg_ff ? S_SIGN : S_EMIT;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free && ptr_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs to the handshake, the digit bank and the output register.
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      ctrl.clear     = accept;
      ctrl.shift     = (state_ff == S_CONV);
      ctrl.bit_in    = mag_ff[VALUE_BITS-1];
      ctrl.base      = base_ff;
      ctrl.negative  = neg_ff;
      emit.load      = 1'b0;
      emit.char_code = digit_char(stat.digit);
      emit.last      = (ptr_ff == '0);
      unique case (state_ff)
         S_SIGN: begin
            emit.load      = out_free;
            emit.char_code = CH_MINUS;
            emit.last      = 1'b0;
         end
         S_EMIT: begin
            emit.load = out_free;
         end
         default: begin
            emit.load = 1'b0;
         end
      endcase
   end

   assign ptr = ptr_ff;

   // Working registers: magnitude shifter, bit counter, digit pointer, sign and radix.
   always_comb begin
      mag_in  = mag_ff;
      cnt_in  = cnt_ff;
      ptr_in  = ptr_ff;
      neg_in  = neg_ff;
      base_in = base_ff;
      if (accept) begin
         neg_in = req_neg;
         if (req_neg) begin
            mag_in = ~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1};
         end else begin
            mag_in = req_value;
         end
         unique case (op_type'(req_op))
            OP_HEX:  base_in = BASE_HEX;
            OP_OCT:  base_in = BASE_OCT;
            default: base_in = BASE_DEC;
         endcase
         cnt_in = CNT_W'(VALUE_BITS - 1);
      end
      if (state_ff == S_CONV) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            ptr_in = neg_ff ? PTR_W'(START_NEG) : PTR_W'(START_POS);
         end
      end
      if (state_ff == S_SCAN && scan_skip) begin
         ptr_in = ptr_ff - 1'b1;
      end
      if (state_ff == S_EMIT && out_free && ptr_ff != '0) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      cnt_ff  <= cnt_in;
      ptr_ff  <= ptr_in;
      neg_ff  <= neg_in;
      base_ff <= base_in;
   end

endmodule

/* rtl/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII converter: sequencer, digit bank and output register.
//
// Usage: each request transfer carries a number (req_value) and a format
// (req_op: unsigned decimal, signed decimal, uppercase hexadecimal, octal).
// The block answers with one response transfer per ASCII character, most
// significant digit first, leading zeros suppressed, a single '0' for zero,
// and a leading '-' for a negative value in signed decimal mode.
// rsp_last marks the final character of each number.
// Operation: after the request transfer the digit bank takes in the number
// (one bit of the number per cycle through the shared doubling unit), then
// a leading-zero scan steps the digit pointer past leading zero digits,
// then the sequencer loads the characters into the output register, the
// '-' first if there is one. req_ready is high only while the sequencer is
// idle; the next request can be taken while the final character still waits
// in the output register. If the receiver stalls, the character in the
// output register holds and the sequencer waits before it loads the next
// character. Synchronous reset returns the sequencer to idle and empties
// the output register.
module integer_to_ascii_radix
   import iar_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last
);

   localparam int NDIG  = num_digits(VALUE_BITS);
   localparam int PTR_W = $clog2(NDIG);

   bank_ctrl_type    ctrl;
   bank_stat_type    stat;
   emit_type         emit;
   logic [PTR_W-1:0] ptr;
   logic             out_free;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   iar_sequencer #(
      .VALUE_BITS (VALUE_BITS),
      .NDIG       (NDIG),
      .PTR_W      (PTR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_value (req_value),
      .out_free  (out_free),
      .emit      (emit),
      .ctrl      (ctrl),
      .ptr       (ptr),
      .stat      (stat)
   );

   iar_digit_bank #(
      .VALUE_BITS (VALUE_BITS),
      .NDIG       (NDIG),
      .PTR_W      (PTR_W)
   ) u_bank (
      .clock (clock),
      .ctrl  (ctrl),
      .ptr   (ptr),
      .stat  (stat)
   );

   // Output register: free when empty or when its character transfers this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit.load;
      end
      if (emit.load) begin
         rsp_char_in = emit.char_code;
         rsp_last_in = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* verif/integer_to_ascii_radix_tb.sv */
// Self-checking testbench of the integer to ASCII radix converter.
module integer_to_ascii_radix_tb
   import iar_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB            = VALUE_BITS_DEF;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [7:0] ASCII_A = 8'h41;

   // One character as the block should send it.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_item;

   // Scoreboard: predicts the characters of each number and checks the output stream.
   class char_scoreboard;
      char_item expected_chars[$];
      int       error_count;

      function new();
         error_count = 0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      // Convert one accepted number into its expected characters.
      function void note_number(op_type op, logic [VB-1:0] value);
         logic [VB-1:0] magnitude;
         logic [3:0]    digits [MAX_CHARS];
         logic          negative;
         int unsigned   radix;
         int            room;
         int            count;
         char_item      ch;
         negative  = (op == OP_SDEC) && value[VB-1];
         magnitude = negative ? (~value + 1'b1) : value;
         case (op)
            OP_HEX:  radix = 16;
            OP_OCT:  radix = 8;
            default: radix = 10;
         endcase
         room  = negative ? MAX_CHARS - 1 : MAX_CHARS;
         count = 0;
         // Collect digits least significant first; zero gives a single digit.
         if (magnitude == '0) begin
            digits[0] = 4'd0;
            count = 1;
         end
         while (magnitude != '0) begin
            if (count < room) begin
               digits[count] = 4'(magnitude % radix);
               count++;
            end
            magnitude = magnitude / radix;
         end
         if (negative) begin
            ch.code = CH_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
         end
         // Emit most significant digit first.
         for (int i = count - 1; i >= 0; i--) begin
            ch.code = (digits[i] < 4'd10) ? CH_ZERO + 8'(digits[i])
                                          : ASCII_A + 8'(digits[i]) - 8'd10;
            ch.last = (i == 0);
            expected_chars.push_back(ch);
         end
      endfunction

      // Compare one received character with the oldest expectation.
      task check_char(logic [7:0] code, logic last);
         char_item want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b", code, last));
         end else begin
            want = expected_chars.pop_front();
            if (code !== want.code) begin
               report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h", code, want.code));
            end
            if (last !== want.last) begin
               report_mismatch($sformatf("last %0b, expected %0b (char 0x%02h)",
                                         last, want.last, want.code));
            end
         end
      endtask

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [1:0]    req_op;
   logic [VB-1:0] req_value;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [7:0]    rsp_char_code;
   logic          rsp_last;

   char_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   int  hold_left;
   int  cycle_count;

   integer_to_ascii_radix i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   // Free-running clock, 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Known values on all inputs from time zero.
   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_UDEC;
      req_value      = '0;
      rsp_ready      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      hold_left      = 0;
      cycle_count    = 0;
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Check every character transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_char_code, rsp_last);
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Offer one number and wait for its transfer.
   task automatic send_number(op_type op, logic [VB-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.note_number(op, value);
   endtask

   // Values weighted toward short numbers, sign boundaries and powers of two.
   function automatic logic [VB-1:0] random_value();
      logic [VB-1:0] v;
      case ($urandom_range(0, 5))
         0:       v = $urandom;
         1:       v = $urandom_range(0, 20);
         2:       v = $urandom >> $urandom_range(1, VB - 1);
         3:       v = '0 - VB'($urandom_range(1, 20));
         4:       v = (VB'(1) << $urandom_range(0, VB - 1)) - VB'($urandom_range(0, 1));
         default: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                       {(VB - 1){$urandom_range(0, 1) ? 1'b1 : 1'b0}}};
      endcase
      return v;
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_number(op_type'($urandom_range(0, 3)), random_value());
      end
   endtask

   // Extremes of every format, two full-length numbers and a one-digit octal number.
   task automatic run_directed();
      logic [VB-1:0] edge_values [5];
      op_type        op;
      edge_values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF};
      op = op.first();
      forever begin
         foreach (edge_values[i]) begin
            send_number(op, edge_values[i]);
         end
         if (op == op.last()) break;
         op = op.next();
      end
      send_number(OP_UDEC, 32'd1000000000);
      send_number(OP_HEX, 32'hABCD_EF01);
      send_number(OP_OCT, 32'o7);
   endtask

   // Main sequence: reset, directed numbers, random phases, back-pressure, drain.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Idle patterns for the random numbers.
      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(16);
      send_idle_pct = 74; recv_stall_pct = 0;  send_random(16);
      send_idle_pct = 0;  recv_stall_pct = 74; send_random(16);
      send_idle_pct = 29; recv_stall_pct = 29; send_random(16);

      // Long receiver hold-off while numbers keep coming.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      send_random(12);

      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* integer_to_ascii_radix.f */
rtl/iar_pkg.sv
rtl/iar_digit_bank.sv
rtl/iar_sequencer.sv
rtl/integer_to_ascii_radix.sv
verif/integer_to_ascii_radix_tb.sv
